[hw/rtl/rbd_pkg.sv]
package rbd_pkg;

    // Default store geometry.
    localparam int RBD_DEPTH     = 1024;
    localparam int RBD_WORD_BITS = 32;

    // Command codes on the input channel. Codes six and seven are no-ops.
    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_POP_BACK   = 3'd1,
        CMD_PUSH_FRONT = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ       = 3'd4,
        CMD_WRITE      = 3'd5
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Per-command outcome handed from the controller to the result pipeline.
    typedef struct packed {
        t_status status;
        logic    is_read;
    } t_ctrl_res;

endpackage

[hw/rtl/rbd_mem.sv]
module rbd_mem
    import rbd_pkg::*;
#(
    parameter int DEPTH     = RBD_DEPTH,
    parameter int WORD_BITS = RBD_WORD_BITS,
    parameter int AW        = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_addr,
    input  logic [WORD_BITS-1:0] i_wdata,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_store [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    // Single port, registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_store[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/rbd_ctrl.sv]
module rbd_ctrl
    import rbd_pkg::*;
#(
    parameter int DEPTH = RBD_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [2:0]    i_command,
    input  logic [AW-1:0] i_position,
    input  logic          i_cfg_fire,
    input  logic [CW-1:0] i_cfg_capacity,
    output logic          o_mem_we,
    output logic          o_mem_re,
    output logic [AW-1:0] o_mem_addr,
    output t_ctrl_res     o_res,
    output logic [CW-1:0] o_count_next,
    output logic [CW-1:0] o_count,
    output logic [CW-1:0] o_capacity
);

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_cap, n_cap;

    logic          full, empty, out_range;
    logic [CW-1:0] offset;
    logic [CW:0]   sum, wrapped;
    logic [AW-1:0] slot, head_dec, head_inc;
    logic [CW-1:0] head_inc_w;
    logic [CW-1:0] cfg_clamped;
    logic          we, re;
    t_ctrl_res     res;

    assign full      = r_count >= r_cap;
    assign empty     = r_count == '0;
    assign out_range = CW'(i_position) >= r_count;

    // Logical offset of the entry the command touches.
    always_comb begin
        case (t_cmd'(i_command))
            CMD_POP_BACK:  offset = r_count - 1'b1;
            CMD_POP_FRONT: offset = '0;
            CMD_READ,
            CMD_WRITE:     offset = CW'(i_position);
            default:       offset = r_count;
        endcase
    end

    // Physical slot: head plus offset, wrapped once at the capacity.
    assign sum     = (CW+1)'(r_head) + (CW+1)'(offset);
    assign wrapped = (sum >= (CW+1)'(r_cap)) ? sum - (CW+1)'(r_cap) : sum;
    assign slot    = wrapped[AW-1:0];

    assign head_dec   = (r_head == '0) ? AW'(r_cap - 1'b1) : r_head - 1'b1;
    assign head_inc_w = CW'(r_head) + 1'b1;
    assign head_inc   = (head_inc_w >= r_cap) ? '0 : AW'(head_inc_w);

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        we          = 1'b0;
        re          = 1'b0;
        o_mem_addr  = slot;
        res.status  = ST_OK;
        res.is_read = 1'b0;
        case (t_cmd'(i_command))
            CMD_PUSH_BACK: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    re          = 1'b1;
                    res.is_read = 1'b1;
                    n_count     = r_count - 1'b1;
                end
            end
            CMD_PUSH_FRONT: begin
                o_mem_addr = head_dec;
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    re          = 1'b1;
                    res.is_read = 1'b1;
                    n_head      = head_inc;
                    n_count     = r_count - 1'b1;
                end
            end
            CMD_READ: begin
                if (out_range) begin
                    res.status = ST_RANGE;
                end else begin
                    re          = 1'b1;
                    res.is_read = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (out_range) begin
                    res.status = ST_RANGE;
                end else begin
                    we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Capacity is clamped to 1..DEPTH.
    always_comb begin
        if (i_cfg_capacity == '0) begin
            cfg_clamped = CW'(1);
        end else if (i_cfg_capacity > CW'(DEPTH)) begin
            cfg_clamped = CW'(DEPTH);
        end else begin
            cfg_clamped = i_cfg_capacity;
        end
        n_cap = r_cap;
        if (i_cfg_fire && !i_fire && empty) begin
            n_cap = cfg_clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_cap   <= CW'(DEPTH);
        end else if (i_fire) begin
            r_head  <= n_head;
            r_count <= n_count;
        end else if (i_cfg_fire && empty) begin
            r_cap  <= n_cap;
            r_head <= '0;
        end
    end

    assign o_mem_we     = i_fire && we;
    assign o_mem_re     = i_fire && re;
    assign o_res        = res;
    assign o_count_next = n_count;
    assign o_count      = r_count;
    assign o_capacity   = r_cap;

endmodule

[hw/rtl/ring_buffer_deque.sv]
// A command's result is loaded into stage one at accept and then into the output register
// once that is free; from the output register it can transfer.
// Throughput: one command per cycle while the result side keeps taking results;
// the single-port store is touched at most once per command, and head and count update at accept.
// Reset: synchronous, active low; the deque comes out empty, head at slot zero and
// capacity at DEPTH. Store contents are not cleared and are never read before written.
module ring_buffer_deque_core
    import rbd_pkg::*;
#(
    parameter int DEPTH     = RBD_DEPTH,
    parameter int WORD_BITS = RBD_WORD_BITS,
    parameter int AW        = $clog2(DEPTH),
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Command channel.
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_command,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic [AW-1:0]        i_position,
    // Result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WORD_BITS-1:0] o_read_word,
    output logic [1:0]           o_status,
    output logic [CW-1:0]        o_count,
    // Capacity write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CW-1:0]        i_cfg_capacity
);

    // The pipeline has two stages. At accept the controller decides the
    // status, updates head and count, and issues any store access. In
    // the next cycle the registered read data comes back, and the finished
    // result is loaded into the output register, once that is free, together
    // with the status and count captured at accept.
    //
    // Because a write happens at the accept edge of its own command and the
    // read of a later command is issued at a later edge, a read always sees
    // every earlier write, so no forwarding path is needed.

    logic                 in_fire;
    logic                 cfg_fire;
    logic                 out_free;
    logic                 s1_move;

    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] mem_rdata;
    t_ctrl_res            ctrl_res;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        count_cur;
    logic [CW-1:0]        capacity_cur;

    // Stage one: store read in flight.
    logic                 r_s1_valid;
    t_ctrl_res            r_s1_res;
    logic [CW-1:0]        r_s1_count;

    // Output register.
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_word;
    t_status              r_out_status;
    logic [CW-1:0]        r_out_count;

    // The output register can take a new result when empty or being drained,
    // and stage one can take a new command when it is empty or moving on.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // Capacity writes are taken at any time; the controller applies them only
    // when the deque is empty and no command transfer happens in that cycle.
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;

    rbd_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (in_fire),
        .i_command      (i_command),
        .i_position     (i_position),
        .i_cfg_fire     (cfg_fire),
        .i_cfg_capacity (i_cfg_capacity),
        .o_mem_we       (mem_we),
        .o_mem_re       (mem_re),
        .o_mem_addr     (mem_addr),
        .o_res          (ctrl_res),
        .o_count_next   (count_next),
        .o_count        (count_cur),
        .o_capacity     (capacity_cur)
    );

    rbd_mem #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (i_value),
        .o_rdata (mem_rdata)
    );

    // Stage one control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage one payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_res   <= ctrl_res;
            r_s1_count <= count_next;
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Output register payload. Only a successful pop or read returns a word;
    // every other result carries zero.
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_word   <= r_s1_res.is_read ? mem_rdata : '0;
            r_out_status <= r_s1_res.status;
            r_out_count  <= r_s1_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_word = r_out_word;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;

    // The element count never exceeds the capacity in use.
    a_count_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        count_cur <= capacity_cur
    ) else $error("element count above capacity");

    // A refused command never returns a word.
    a_zero_word: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_OK |-> r_out_word == '0
    ) else $error("error result carries a nonzero word");

    // An accepted command always lands in stage one.
    a_accept_s1: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid
    ) else $error("accepted command lost before stage one");

    // Stage one holds its result while the output register is stalled.
    a_s1_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_out_ready |=> r_s1_valid && $stable(r_s1_count)
    ) else $error("stage one result dropped under back-pressure");

endmodule

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbd_pkg::*;

    // The block has no names for the two spare command codes; both must be
    // answered with an ok status, a zero word and an unchanged count.
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // Hard stop for the run.
    localparam int CYCLE_LIMIT = 400_000;

    // One result of the command channel, in the order the ports carry it.
    typedef struct packed {
        logic [31:0] word;
        t_status     status;
        logic [10:0] count;
    } t_deque_result;

    // A row of the directed table is either a command or a capacity write.
    // Rows marked as known carry their result; the others go to the predictor.
    typedef enum logic {ROW_CMD, ROW_CAP} t_row_kind;

    typedef struct packed {
        t_row_kind     kind;
        logic [2:0]    cmd;
        logic [31:0]   value;
        logic [9:0]    pos;
        logic [10:0]   cap;
        logic          known;
        t_deque_result res;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 27;

    localparam t_directed_row DIRECTED_TABLE [DIRECTED_ROWS] = '{
        // Fresh after reset: every access on an empty deque is refused.
        '{ROW_CMD, CMD_POP_BACK,   32'h0000_0000, 10'd0,    11'd0, 1'b1,
          '{32'h0, ST_EMPTY, 11'd0}},
        '{ROW_CMD, CMD_POP_FRONT,  32'h0000_0000, 10'd0,    11'd0, 1'b1,
          '{32'h0, ST_EMPTY, 11'd0}},
        '{ROW_CMD, CMD_READ,       32'h0000_0000, 10'd0,    11'd0, 1'b1,
          '{32'h0, ST_RANGE, 11'd0}},
        '{ROW_CMD, CMD_WRITE,      32'hFFFF_FFFF, 10'd1023, 11'd0, 1'b1,
          '{32'h0, ST_RANGE, 11'd0}},
        // The spare codes do nothing, whatever the payload.
        '{ROW_CMD, CMD_SPARE_LO,   32'hFFFF_FFFF, 10'd1023, 11'd0, 1'b1,
          '{32'h0, ST_OK, 11'd0}},
        '{ROW_CMD, CMD_SPARE_HI,   32'hFFFF_FFFF, 10'd1023, 11'd0, 1'b1,
          '{32'h0, ST_OK, 11'd0}},
        // A push at the front from head zero wraps the head to the last slot.
        '{ROW_CMD, CMD_PUSH_BACK,  32'hFFFF_FFFF, 10'd0,    11'd0, 1'b1,
          '{32'h0, ST_OK, 11'd1}},
        '{ROW_CMD, CMD_PUSH_FRONT, 32'h0000_0000, 10'd0,    11'd0, 1'b1,
          '{32'h0, ST_OK, 11'd2}},
        '{ROW_CMD, CMD_READ,       32'h0000_0000, 10'd0,    11'd0, 1'b1,
          '{32'h0, ST_OK, 11'd2}},
        '{ROW_CMD, CMD_READ,       32'h0000_0000, 10'd1,    11'd0, 1'b1,
          '{32'hFFFF_FFFF, ST_OK, 11'd2}},
        '{ROW_CMD, CMD_READ,       32'h0000_0000, 10'd2,    11'd0, 1'b1,
          '{32'h0, ST_RANGE, 11'd2}},
        '{ROW_CMD, CMD_WRITE,      32'h5A5A_5A5A, 10'd0,    11'd0, 1'b1,
          '{32'h0, ST_OK, 11'd2}},
        '{ROW_CMD, CMD_READ,       32'h0000_0000, 10'd1023, 11'd0, 1'b1,
          '{32'h0, ST_RANGE, 11'd2}},
        // The deque is not empty, so this capacity write must be dropped.
        '{ROW_CAP, CMD_PUSH_BACK,  32'h0000_0000, 10'd0,    11'd4, 1'b0, '0},
        '{ROW_CMD, CMD_PUSH_BACK,  32'h1234_5678, 10'd0,    11'd0, 1'b0, '0},
        '{ROW_CMD, CMD_POP_FRONT,  32'h0000_0000, 10'd0,    11'd0, 1'b0, '0},
        '{ROW_CMD, CMD_POP_BACK,   32'h0000_0000, 10'd0,    11'd0, 1'b0, '0},
        '{ROW_CMD, CMD_POP_BACK,   32'h0000_0000, 10'd0,    11'd0, 1'b0, '0},
        // Zero clamps to a single slot, so the second push of either kind is full.
        '{ROW_CAP, CMD_PUSH_BACK,  32'h0000_0000, 10'd0,    11'd0, 1'b0, '0},
        '{ROW_CMD, CMD_PUSH_FRONT, 32'h8000_0001, 10'd0,    11'd0, 1'b1,
          '{32'h0, ST_OK, 11'd1}},
        '{ROW_CMD, CMD_PUSH_BACK,  32'hDEAD_BEEF, 10'd0,    11'd0, 1'b1,
          '{32'h0, ST_FULL, 11'd1}},
        '{ROW_CMD, CMD_PUSH_FRONT, 32'hDEAD_BEEF, 10'd0,    11'd0, 1'b1,
          '{32'h0, ST_FULL, 11'd1}},
        '{ROW_CMD, CMD_READ,       32'h0000_0000, 10'd0,    11'd0, 1'b0, '0},
        '{ROW_CMD, CMD_POP_FRONT,  32'h0000_0000, 10'd0,    11'd0, 1'b0, '0},
        // Everything above the store depth clamps to the full store.
        '{ROW_CAP, CMD_PUSH_BACK,  32'h0000_0000, 10'd0,    11'd2047, 1'b0, '0},
        '{ROW_CMD, CMD_PUSH_BACK,  32'h7FFF_FFFF, 10'd0,    11'd0, 1'b0, '0},
        '{ROW_CMD, CMD_POP_BACK,   32'h0000_0000, 10'd0,    11'd0, 1'b0, '0}
    };

    // Clock, reset and the ports of the block. Every input starts at a known value.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_command = '0;
    logic [31:0] i_value = '0;
    logic [9:0]  i_position = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_read_word;
    logic [1:0]  o_status;
    logic [10:0] o_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_capacity = '0;

    // Shadow copy of the deque, updated at every accepted transfer.
    logic [31:0] shadow_mem [RBD_DEPTH];
    int          shadow_head = 0;
    int          shadow_count = 0;
    int          shadow_cap = RBD_DEPTH;

    // Results still owed by the block, oldest first.
    t_deque_result pending_results [$];

    // Knobs shared between the stimulus and the result-side process.
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;
    bit filling = 1'b1;

    int error_count = 0;
    int cycle_count = 0;
    int cmds_sent = 0;
    int cap_writes = 0;
    int results_seen = 0;
    int full_seen = 0;
    int empty_seen = 0;
    int range_seen = 0;

    ring_buffer_deque_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_position     (i_position),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_word    (o_read_word),
        .o_status       (o_status),
        .o_count        (o_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Physical slot of a logical offset: head plus offset, wrapped once at the
    // capacity in use.
    function automatic int ring_slot(input int offset);
        int s;
        s = shadow_head + offset;
        if (s >= shadow_cap) begin
            s = s - shadow_cap;
        end
        return s;
    endfunction

    // Applies one command to the shadow deque and returns what the block must
    // answer. A refused command leaves the shadow state alone.
    function automatic t_deque_result deque_apply(input logic [2:0] cmd,
                                                  input logic [31:0] val,
                                                  input logic [9:0] pos);
        t_deque_result r;
        r.word   = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH_BACK: begin
                if (shadow_count >= shadow_cap) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_mem[ring_slot(shadow_count)] = val;
                    shadow_count++;
                end
            end
            CMD_POP_BACK: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.word = shadow_mem[ring_slot(shadow_count - 1)];
                    shadow_count--;
                end
            end
            CMD_PUSH_FRONT: begin
                if (shadow_count >= shadow_cap) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_head = (shadow_head == 0) ? shadow_cap - 1 : shadow_head - 1;
                    shadow_mem[shadow_head] = val;
                    shadow_count++;
                end
            end
            CMD_POP_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.word = shadow_mem[shadow_head];
                    shadow_head++;
                    if (shadow_head >= shadow_cap) begin
                        shadow_head = 0;
                    end
                    shadow_count--;
                end
            end
            CMD_READ: begin
                if (int'(pos) >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.word = shadow_mem[ring_slot(int'(pos))];
                end
            end
            CMD_WRITE: begin
                if (int'(pos) >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    shadow_mem[ring_slot(int'(pos))] = val;
                end
            end
            default: begin
            end
        endcase
        r.count = 11'(shadow_count);
        return r;
    endfunction

    // A capacity write only lands on an empty deque; it is clamped to the
    // legal range and sends the head back to slot zero.
    function automatic void deque_set_capacity(input logic [10:0] v);
        int c;
        if (shadow_count != 0) begin
            return;
        end
        c = int'(v);
        if (c < 1) begin
            c = 1;
        end
        if (c > RBD_DEPTH) begin
            c = RBD_DEPTH;
        end
        shadow_cap  = c;
        shadow_head = 0;
    endfunction

    // Words lean toward the two extremes now and then.
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] push_side();
        return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    endfunction

    function automatic logic [2:0] pop_side();
        return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    function automatic logic [2:0] access_side();
        return $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
    endfunction

    // Drives one command transfer. The task starts after the edge that took
    // the previous transfer, so valid either stays high with a new payload or
    // drops for the drawn number of cycles first. The result is predicted at
    // the edge where the transfer happens.
    task automatic issue_cmd(input logic [2:0] cmd, input logic [31:0] val,
                             input logic [9:0] pos, input logic known,
                             input t_deque_result known_res);
        int gap;
        t_deque_result predicted;
        gap = sender_idles ? $urandom_range(0, 12) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = deque_apply(cmd, val, pos);
        pending_results.push_back(known ? known_res : predicted);
        cmds_sent++;
    endtask

    // Stops the command stream and waits until every owed result has come.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Capacity writes happen only with the block idle. Every command yields a
    // result, so the last result means nothing is left in flight.
    task automatic write_capacity(input logic [10:0] v);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_capacity <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        deque_set_capacity(v);
        cap_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random command. Most are pushes and pops that sweep the fill level
    // from empty to full and back; the rest are reads and writes inside the
    // deque, accesses at any position (mostly out of range) and spare codes.
    task automatic random_op();
        int r;
        logic [2:0] cmd;
        logic [9:0] pos;
        r   = $urandom_range(0, 99);
        pos = 10'($urandom_range(0, 1023));
        if (shadow_count == 0) begin
            filling = 1'b1;
        end else if (shadow_count >= shadow_cap) begin
            filling = 1'b0;
        end
        if (r < 5) begin
            cmd = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
        end else if (r < 15) begin
            cmd = access_side();
        end else if (r < 40) begin
            cmd = access_side();
            if (shadow_count > 0) begin
                pos = 10'($urandom_range(0, shadow_count - 1));
            end
        end else if (($urandom_range(0, 99) < 80) == filling) begin
            cmd = push_side();
        end else begin
            cmd = pop_side();
        end
        issue_cmd(cmd, random_word(), pos, 1'b0, '0);
    endtask

    // Empties the deque with pops from either end.
    task automatic empty_deque();
        while (shadow_count != 0) begin
            issue_cmd(pop_side(), random_word(), 10'($urandom_range(0, 1023)), 1'b0, '0);
        end
    endtask

    // Result side. Before each result transfer, ready is held low for a drawn
    // number of cycles, so stalls land on every stage of the pipeline.
    initial begin : result_sink
        int stall;
        wait (i_rst_n);
        forever begin
            stall = receiver_idles ? $urandom_range(0, 12) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Every result transfer is checked against the oldest owed result.
    always @(posedge i_clk) begin : result_check
        t_deque_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            case (o_status)
                ST_FULL:  full_seen++;
                ST_EMPTY: empty_seen++;
                ST_RANGE: range_seen++;
                default: begin
                end
            endcase
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result with nothing owed: word %h status %0d count %0d",
                         $time, o_read_word, o_status, o_count);
            end else begin
                want = pending_results.pop_front();
                if (o_read_word !== want.word) begin
                    error_count++;
                    $display("%0t: read_word expected %h actual %h",
                             $time, want.word, o_read_word);
                end
                if (o_status !== want.status) begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                end
                if (o_count !== want.count) begin
                    error_count++;
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, o_count);
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run did not finish, %0d results still owed",
                 $time, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        t_directed_row row;
        logic [10:0] cap_val;
        int n;

        // Reset is held low from the start and released on a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: walk the table.
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED_TABLE[i];
            if (row.kind == ROW_CAP) begin
                write_capacity(row.cap);
            end else begin
                issue_cmd(row.cmd, row.value, row.pos, row.known, row.res);
            end
        end

        // Random phases at small capacities. The first one runs without any
        // idling on either side; later ones mix the idling at random.
        for (int ph = 0; ph < 6; ph++) begin
            sender_idles   = (ph == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            receiver_idles = (ph == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            // A stray capacity write lands only if the deque happens to be empty.
            if ($urandom_range(0, 1)) begin
                write_capacity(11'($urandom_range(0, 2047)));
            end
            empty_deque();
            case (ph)
                0: cap_val = 11'd1;
                1: cap_val = 11'd2;
                2: cap_val = 11'($urandom_range(3, 8));
                3: cap_val = 11'($urandom_range(9, 40));
                4: cap_val = 11'd0;
                default: cap_val = 11'($urandom_range(41, 200));
            endcase
            write_capacity(cap_val);
            filling = 1'b1;
            for (int k = 0; k < 40; k++) begin
                // Once in the run, the stream stops mid-phase until the block
                // has handed back every result.
                if (ph == 2 && k == 20) begin
                    drain_results();
                end
                random_op();
            end
        end

        // Full-size phase: fill the whole store from both ends, touching
        // elements along the way, then hit it while full.
        empty_deque();
        write_capacity(11'($urandom_range(1025, 2047)));
        n = 0;
        while (shadow_count < shadow_cap) begin
            if (n % 128 == 0) begin
                sender_idles   = 1'($urandom_range(0, 1));
                receiver_idles = 1'($urandom_range(0, 1));
            end
            n++;
            if ($urandom_range(0, 9) == 0 && shadow_count > 0) begin
                issue_cmd(access_side(), random_word(),
                          10'($urandom_range(0, shadow_count - 1)), 1'b0, '0);
            end else begin
                issue_cmd(push_side(), random_word(), 10'd0, 1'b0, '0);
            end
        end
        issue_cmd(CMD_PUSH_BACK, random_word(), 10'd0, 1'b0, '0);
        issue_cmd(CMD_PUSH_FRONT, random_word(), 10'd0, 1'b0, '0);
        issue_cmd(CMD_READ, 32'h0, 10'd1023, 1'b0, '0);
        issue_cmd(CMD_WRITE, 32'hA5A5_5A5A, 10'd1023, 1'b0, '0);
        issue_cmd(CMD_READ, 32'h0, 10'd1023, 1'b0, '0);
        filling = 1'b0;
        repeat (20) random_op();
        // The deque is far from empty, so this write must leave capacity alone.
        write_capacity(11'd3);
        repeat (10) random_op();

        // Wait for the last results, then keep the clock running to catch anything stray.
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d commands and %0d capacity writes, %0d results checked.",
                 cmds_sent, cap_writes, results_seen);
        $display("Refusals seen: %0d full, %0d empty, %0d out of range; %0d errors.",
                 full_seen, empty_seen, range_seen, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
